@@ rtl/hfs_pkg.sv @@
// hfs_pkg: shared types, codes and constants of the first-seen group numbering block.
// Used by hfs_ctrl, hfs_datapath and hash_first_seen_group_id. No dependencies.
`timescale 1ns / 1ps
package hfs_pkg;

   localparam int TABLE_BITS_DEF = 12;     // default log2 of table depth
   localparam int KEY_W          = 64;
   localparam int GROUP_W        = 13;
   localparam int EPOCH_W        = 8;      // table generation tag
   localparam int HB_W           = 5;      // holds an effective hash_bits up to 20
   localparam int CSR_INDEX_W    = 1;
   localparam int CSR_DATA_W     = 4;
   localparam int KIND_W         = 2;

   localparam logic [31:0]         FIB_MULT  = 32'd3141592653;
   localparam logic [GROUP_W-1:0]  GROUP_MAX = 13'd8191;
   localparam logic [HB_W-1:0]     HB_MIN    = 5'd8;

   // key kinds
   localparam logic [KIND_W-1:0] KIND_INT    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DOUBLE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PTR    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_PTR_ALT = 2'd3;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_TYPE  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HASH_BITS = 1'd1;

   typedef struct packed {
      logic [KEY_W-1:0] key_bits;
      logic             start_new;
   } req_type;

   typedef struct packed {
      logic [GROUP_W-1:0] group_id;
      logic               is_new;
      logic               table_full;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_INIT_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_ITEM_CLEAR,
      ST_ISSUE,
      ST_CHECK
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;         // latch request
      logic clr_write;      // clearing pass writes one entry
      logic epoch_restart;  // generation back to 1 (with a clearing pass)
      logic epoch_bump;     // next generation: table reads as empty
      logic count_clear;
      logic do_hash;        // register fold * constant
      logic do_issue;       // first probe read
      logic do_step;        // advance probe, read next slot
      logic do_insert;      // store key, new group
      logic rsp_hit;
      logic rsp_full;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic start_new;
      logic epoch_max;
      logic clr_done;
      logic slot_free;
      logic slot_match;
      logic probe_last;
      logic count_full;
   } status_type;

endpackage

@@ rtl/hash_first_seen_group_id.sv @@
// hash_first_seen_group_id: top level, configuration registers and core wiring.
// Depends on hfs_pkg, hfs_ctrl and hfs_datapath.
`timescale 1ns / 1ps
// Gives each key of a request stream a dense group number (1, 2, ...) in first-seen
// order, using an open-addressing table with linear probing over 2^hash_bits slots.
// A request is taken when start is high and busy is low; its response shows on
// rsp_payload for exactly one cycle with rsp_valid high, registered after the check
// state, and the receiver cannot stall it. A key found or placed at its first probe
// passes the hash, issue and check states before the next request can be taken;
// each further probe repeats the check state, set by the single read port of the slot memory.
// A full probe sweep with no match and no free slot reports table_full.
// start_new empties the table by moving to a new table generation; after reset,
// and on every 255th start_new when the generation tag wraps, a clearing pass
// that writes all 2^TABLE_BITS slots runs with busy high.
// Configuration writes (csr_we) are taken in any cycle, but are meant for idle time.
module hash_first_seen_group_id #(
   parameter int TABLE_BITS = hfs_pkg::TABLE_BITS_DEF   // 8 to 20
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              start,
   output logic                              busy,
   input  hfs_pkg::req_type                  req_payload,
   // response channel
   output logic                              rsp_valid,
   output hfs_pkg::rsp_type                  rsp_payload,
   // configuration
   input  logic                              csr_we,
   input  logic [hfs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [hfs_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic [hfs_pkg::KIND_W-1:0] key_type_ff;
   logic [3:0]                 hash_bits_ff;
   logic [hfs_pkg::KIND_W-1:0] kind;
   logic [hfs_pkg::HB_W-1:0]   hb_ext, hb;

   hfs_pkg::cmd_type    cmd;
   hfs_pkg::status_type status;

   // config registers, values masked to register width
   always_ff @(posedge clock) begin
      if (reset) begin
         key_type_ff  <= hfs_pkg::KIND_INT;
         hash_bits_ff <= 4'd12;
      end else if (csr_we) begin
         unique case (csr_index)
            hfs_pkg::CSR_KEY_TYPE:  key_type_ff  <= csr_wdata[hfs_pkg::KIND_W-1:0];
            hfs_pkg::CSR_HASH_BITS: hash_bits_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // kind 3 behaves as pointer
   assign kind = (key_type_ff == hfs_pkg::KIND_PTR_ALT) ? hfs_pkg::KIND_PTR : key_type_ff;

   // clamp hash_bits into [8, TABLE_BITS]
   assign hb_ext = hfs_pkg::HB_W'(hash_bits_ff);
   always_comb begin
      priority if (hb_ext < hfs_pkg::HB_MIN)                hb = hfs_pkg::HB_MIN;
      else if (hb_ext > hfs_pkg::HB_W'(TABLE_BITS))        hb = hfs_pkg::HB_W'(TABLE_BITS);
      else                                                 hb = hb_ext;
   end

   hfs_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   hfs_datapath #(
      .TABLE_BITS (TABLE_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .kind        (kind),
      .hb          (hb),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ rtl/hfs_ctrl.sv @@
// hfs_ctrl: sequencer of clearing pass, hash, probe and insert.
// Depends on hfs_pkg; drives hfs_datapath through cmd_type, reads status_type.
`timescale 1ns / 1ps
module hfs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  hfs_pkg::status_type status,
   output hfs_pkg::cmd_type    cmd
);

   hfs_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hfs_pkg::ST_INIT_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         hfs_pkg::ST_INIT_CLEAR: begin
            cmd.clr_write = 1'b1;
            if (status.clr_done) state_in = hfs_pkg::ST_IDLE;
         end
         hfs_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = hfs_pkg::ST_HASH;
            end
         end
         hfs_pkg::ST_HASH: begin
            cmd.do_hash = 1'b1;
            state_in    = hfs_pkg::ST_ISSUE;
            if (status.start_new) begin
               cmd.count_clear = 1'b1;
               if (status.epoch_max) begin
                  cmd.epoch_restart = 1'b1;
                  state_in          = hfs_pkg::ST_ITEM_CLEAR;
               end else begin
                  cmd.epoch_bump = 1'b1;
               end
            end
         end
         hfs_pkg::ST_ITEM_CLEAR: begin
            cmd.clr_write = 1'b1;
            if (status.clr_done) state_in = hfs_pkg::ST_ISSUE;
         end
         hfs_pkg::ST_ISSUE: begin
            cmd.do_issue = 1'b1;
            state_in     = hfs_pkg::ST_CHECK;
         end
         hfs_pkg::ST_CHECK: begin
            state_in = hfs_pkg::ST_IDLE;
            priority if (status.slot_free) begin
               if (status.count_full) cmd.rsp_full  = 1'b1;
               else                   cmd.do_insert = 1'b1;
            end else if (status.slot_match) begin
               cmd.rsp_hit = 1'b1;
            end else if (status.probe_last) begin
               cmd.rsp_full = 1'b1;
            end else begin
               cmd.do_step = 1'b1;
               state_in    = hfs_pkg::ST_CHECK;
            end
         end
         default: begin
            state_in = hfs_pkg::ST_INIT_CLEAR;
         end
      endcase
   end

endmodule

@@ rtl/hfs_datapath.sv @@
// hfs_datapath: key register, hash multiplier, probe counters, slot memory, compare, result.
// Depends on hfs_pkg; commanded by hfs_ctrl.
`timescale 1ns / 1ps
module hfs_datapath #(
   parameter int TABLE_BITS = hfs_pkg::TABLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  hfs_pkg::req_type              req_payload,
   input  logic [hfs_pkg::KIND_W-1:0]    kind,
   input  logic [hfs_pkg::HB_W-1:0]      hb,
   input  hfs_pkg::cmd_type              cmd,
   output hfs_pkg::status_type           status,
   output logic                          rsp_valid,
   output hfs_pkg::rsp_type              rsp_payload
);

   localparam int SLOTS = 1 << TABLE_BITS;

   typedef struct packed {
      logic [hfs_pkg::EPOCH_W-1:0] epoch;
      logic [hfs_pkg::KEY_W-1:0]   key;
      logic [hfs_pkg::GROUP_W-1:0] group;
   } entry_type;

   entry_type mem [SLOTS];

   logic [hfs_pkg::KEY_W-1:0]   key_ff, key_in;
   logic                        start_new_ff;
   logic [31:0]                 prod_ff, prod_in, fold;
   logic [TABLE_BITS-1:0]       pos_ff, probe_ff, clr_addr_ff;
   logic [TABLE_BITS-1:0]       pos_calc, pos_next, mask;
   logic [TABLE_BITS:0]         mask_wide;
   logic [5:0]                  shamt;
   logic [hfs_pkg::EPOCH_W-1:0] epoch_ff;
   logic [hfs_pkg::GROUP_W-1:0] count_ff, count_inc;
   entry_type                   rd_data_ff, wdata;
   logic [TABLE_BITS-1:0]       waddr, raddr;
   logic                        we;
   logic                        rsp_valid_ff, rsp_valid_in;
   hfs_pkg::rsp_type            rsp_ff, rsp_in;

   function automatic logic is_nan(input logic [63:0] k);
      return (k[62:52] == 11'h7ff) && (k[51:0] != 52'd0);
   endfunction

   function automatic logic keys_equal(input logic [63:0] a, input logic [63:0] b,
                                       input logic [hfs_pkg::KIND_W-1:0] k);
      logic eq;
      eq = (a == b);
      if (k == hfs_pkg::KIND_INT) begin
         eq = (a[31:0] == b[31:0]);
      end else if (k == hfs_pkg::KIND_DOUBLE) begin
         if (is_nan(a) || is_nan(b))         eq = 1'b0;
         else if ((a[62:0] | b[62:0]) == '0) eq = 1'b1;   // +0 == -0
      end
      return eq;
   endfunction

   // key capture; integer keys keep only the low word
   assign key_in = (kind == hfs_pkg::KIND_INT) ? {32'd0, req_payload.key_bits[31:0]}
                                               : req_payload.key_bits;

   assign fold    = (kind == hfs_pkg::KIND_DOUBLE) ? 32'(key_ff[31:0] + key_ff[63:32])
                                                   : key_ff[31:0];
   assign prod_in = 32'(fold * hfs_pkg::FIB_MULT);

   assign mask_wide = ((TABLE_BITS+1)'(1) << hb) - (TABLE_BITS+1)'(1);
   assign mask      = mask_wide[TABLE_BITS-1:0];
   assign shamt     = 6'd32 - 6'(hb);
   assign pos_calc  = TABLE_BITS'(prod_ff >> shamt) & mask;
   assign pos_next  = TABLE_BITS'(pos_ff + TABLE_BITS'(1)) & mask;
   assign count_inc = count_ff + hfs_pkg::GROUP_W'(1);

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         key_ff       <= key_in;
         start_new_ff <= req_payload.start_new;
      end
      if (cmd.do_hash) prod_ff <= prod_in;
      if (cmd.do_issue) begin
         pos_ff   <= pos_calc;
         probe_ff <= '0;
      end else if (cmd.do_step) begin
         pos_ff   <= pos_next;
         probe_ff <= probe_ff + TABLE_BITS'(1);
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff  <= '0;
         epoch_ff     <= hfs_pkg::EPOCH_W'(1);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_write) clr_addr_ff <= clr_addr_ff + TABLE_BITS'(1);
         if (cmd.epoch_restart)   epoch_ff <= hfs_pkg::EPOCH_W'(1);
         else if (cmd.epoch_bump) epoch_ff <= epoch_ff + hfs_pkg::EPOCH_W'(1);
         if (cmd.count_clear)    count_ff <= '0;
         else if (cmd.do_insert) count_ff <= count_inc;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // slot memory: one write, one registered read per cycle
   always_comb begin
      we          = cmd.clr_write | cmd.do_insert;
      waddr       = cmd.clr_write ? clr_addr_ff : pos_ff;
      wdata.epoch = cmd.clr_write ? '0 : epoch_ff;
      wdata.key   = key_ff;
      wdata.group = count_inc;
      raddr       = cmd.do_step ? pos_next : pos_calc;
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_data_ff <= mem[raddr];
   end

   always_comb begin
      status.start_new  = start_new_ff;
      status.epoch_max  = (epoch_ff == '1);
      status.clr_done   = (clr_addr_ff == '1);
      status.slot_free  = (rd_data_ff.epoch != epoch_ff);
      status.slot_match = keys_equal(rd_data_ff.key, key_ff, kind);
      status.probe_last = (probe_ff == mask);
      status.count_full = (count_ff == hfs_pkg::GROUP_MAX);
   end

   // result commands are one-hot; no command leaves the response cleared
   always_comb begin
      rsp_valid_in = cmd.do_insert | cmd.rsp_hit | cmd.rsp_full;
      rsp_in       = '0;
      if (cmd.do_insert) begin
         rsp_in.group_id = count_inc;
         rsp_in.is_new   = 1'b1;
      end else if (cmd.rsp_hit) begin
         rsp_in.group_id = rd_data_ff.group;
      end else if (cmd.rsp_full) begin
         rsp_in.table_full = 1'b1;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_insert_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.do_insert |-> status.slot_free && !status.count_full)
      else $error("insert into occupied slot or past group limit");

   a_count_steps: assert property (@(posedge clock) disable iff (reset)
      cmd.do_insert |=> count_ff == hfs_pkg::GROUP_W'($past(count_ff) + 13'd1))
      else $error("group count did not advance on insert");

   a_full_means_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.table_full |-> rsp_ff.group_id == '0 && !rsp_ff.is_new)
      else $error("full result carries a group");

   a_no_clear_during_probe: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_write |-> !cmd.do_insert && !cmd.do_step && !rsp_valid_in)
      else $error("clearing pass overlaps a probe");
`endif

endmodule

@@ tb/hash_first_seen_group_id_tb.sv @@
// hash_first_seen_group_id_tb: self-checking bench for the first-seen group numbering block.
// Holds a group-number predictor class plus request/config drivers; needs hfs_pkg and the RTL.
`timescale 1ns / 1ps
module hash_first_seen_group_id_tb;
   import hfs_pkg::*;

   localparam int TABLE_BITS   = TABLE_BITS_DEF;
   localparam int SLOTS        = 1 << TABLE_BITS;
   localparam int KEY_TARGET   = 1250;       // keys to send before winding down
   localparam int FILL_PHASE   = 5;          // phase that packs a 256-slot table to the brim
   localparam int DRAIN_CYCLES = 16;         // wait after the last expected response before the final check
   // The slowest legal run comes from full-table sweeps of 256 probes, several clearing
   // passes of the whole table, and sender gaps; CYCLE_LIMIT must exceed it.
   localparam int CYCLE_LIMIT  = 1_000_000;

   // Mirrors the block: open-addressing table with linear probing, group numbers
   // handed out in first-seen order. Predicts at request accept, checks at response.
   class group_numbering;
      bit                  slot_used  [SLOTS];
      logic [KEY_W-1:0]    slot_key   [SLOTS];
      logic [GROUP_W-1:0]  slot_group [SLOTS];
      logic [GROUP_W-1:0]  group_count;
      logic [KIND_W-1:0]   key_kind;
      logic [CSR_DATA_W-1:0] hash_bits;
      rsp_type             pending_groups[$];
      int                  failures;
      int                  n_new, n_hit, n_full;

      function new();
         foreach (slot_used[i]) slot_used[i] = 1'b0;
         group_count = '0;
         key_kind    = KIND_INT;
         hash_bits   = 4'd12;
         failures    = 0;
         n_new = 0; n_hit = 0; n_full = 0;
      endfunction

      // registers are masked to their own width
      function void set_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         if (idx == CSR_KEY_TYPE) key_kind = val[KIND_W-1:0];
         else if (idx == CSR_HASH_BITS) hash_bits = val;
      endfunction

      function logic [31:0] fold_of(logic [KEY_W-1:0] k, logic [KIND_W-1:0] kind);
         if (kind == KIND_DOUBLE) return k[31:0] + k[63:32];
         return k[31:0];
      endfunction

      function bit is_nan(logic [KEY_W-1:0] k);
         return k[62:52] == 11'h7ff && k[51:0] != '0;
      endfunction

      // double: IEEE equality, so +0 == -0 and NaN never matches
      function bit same_key(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b,
                            logic [KIND_W-1:0] kind);
         if (kind == KIND_INT) return a[31:0] == b[31:0];
         if (kind == KIND_DOUBLE) begin
            if (is_nan(a) || is_nan(b)) return 1'b0;
            if (((a | b) & 64'h7fff_ffff_ffff_ffff) == '0) return 1'b1;
         end
         return a == b;
      endfunction

      function void note_key(req_type r);
         logic [KIND_W-1:0] kind;
         logic [KEY_W-1:0]  k;
         logic [31:0]       product;
         int unsigned       hb, mask, pos;
         rsp_type           res;
         kind = (key_kind == KIND_PTR_ALT) ? KIND_PTR : key_kind;
         hb   = 32'(hash_bits);
         if (hb < 32'(HB_MIN)) hb = 32'(HB_MIN);
         if (hb > TABLE_BITS) hb = TABLE_BITS;
         mask = (1 << hb) - 1;
         if (r.start_new) begin
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            group_count = '0;
         end
         k = r.key_bits;
         if (kind == KIND_INT) k[63:32] = '0;
         product = FIB_MULT * fold_of(k, kind);
         pos = (product >> (32 - hb)) & mask;
         // default: sweep found neither match nor room
         res.group_id   = '0;
         res.is_new     = 1'b0;
         res.table_full = 1'b1;
         for (int n = 0; n < (1 << hb); n++) begin
            if (!slot_used[pos]) begin
               if (group_count < GROUP_MAX) begin
                  group_count     = group_count + 1'b1;
                  slot_used[pos]  = 1'b1;
                  slot_key[pos]   = k;
                  slot_group[pos] = group_count;
                  res.group_id    = group_count;
                  res.is_new      = 1'b1;
                  res.table_full  = 1'b0;
               end
               break;
            end
            if (same_key(slot_key[pos], k, kind)) begin
               res.group_id   = slot_group[pos];
               res.table_full = 1'b0;
               break;
            end
            pos = (pos + 1) & mask;
         end
         if (res.is_new) n_new++;
         else if (res.table_full) n_full++;
         else n_hit++;
         pending_groups.push_back(res);
      endfunction

      function void check_group(rsp_type got);
         rsp_type want;
         if (pending_groups.size() == 0) begin
            $error("response with no request outstanding: group_id %0d", got.group_id);
            failures++;
            return;
         end
         want = pending_groups.pop_front();
         if (got.group_id !== want.group_id) begin
            $error("group_id: expected %0d, got %0d", want.group_id, got.group_id);
            failures++;
         end
         if (got.is_new !== want.is_new) begin
            $error("is_new: expected %0b, got %0b", want.is_new, got.is_new);
            failures++;
         end
         if (got.table_full !== want.table_full) begin
            $error("table_full: expected %0b, got %0b", want.table_full, got.table_full);
            failures++;
         end
      endfunction

      function int outstanding();
         return pending_groups.size();
      endfunction

      function void flag_leftover();
         if (pending_groups.size() != 0) begin
            $error("%0d expected responses never arrived", pending_groups.size());
            failures++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start;
   logic                   busy;
   req_type                req_payload;
   logic                   rsp_valid;
   rsp_type                rsp_payload;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   group_numbering   groups;
   logic [KEY_W-1:0] key_pool[$];
   int               burst_left = 0;
   int               keys_sent  = 0;
   int               phase_count = 0;
   int unsigned      cycle_count = 0;

   hash_first_seen_group_id #(.TABLE_BITS(TABLE_BITS)) dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   // 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // watchdog: a hung handshake or a lost response ends up here
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   // responses cannot be stalled, so every strobe is checked at the edge that ends it
   always @(posedge clock) begin
      if (!reset && rsp_valid) groups.check_group(rsp_payload);
   end

   // Signed zeros, infinities and NaNs (random sign and payload).
   function automatic logic [KEY_W-1:0] special_double();
      logic [KEY_W-1:0] k;
      k = {$urandom(), $urandom()};
      case ($urandom_range(0, 3))
         0: k = '0;
         1: k = 64'h8000_0000_0000_0000;
         2: k = {k[63], 11'h7ff, 52'h0};
         default: begin
            k[62:52] = 11'h7ff;
            if (k[51:0] == '0) k[0] = 1'b1;
         end
      endcase
      return k;
   endfunction

   // Mostly pool keys so repeats hit; the rest are fresh keys as noise.
   function automatic logic [KEY_W-1:0] pick_key(logic [KIND_W-1:0] kind);
      logic [KEY_W-1:0] k;
      if (key_pool.size() != 0 && $urandom_range(0, 9) < 7)
         k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      else
         k = {$urandom(), $urandom()};
      // integer keys ignore the upper half, so vary it on repeats
      if (kind == KIND_INT && $urandom_range(0, 1)) k[63:32] = $urandom();
      if (kind == KIND_DOUBLE && $urandom_range(0, 7) == 0) k = special_double();
      return k;
   endfunction

   task automatic refill_pool(input logic [KIND_W-1:0] kind, input int n);
      key_pool.delete();
      repeat (n) begin
         if (kind == KIND_DOUBLE && $urandom_range(0, 3) == 0)
            key_pool.push_back(special_double());
         else
            key_pool.push_back({$urandom(), $urandom()});
      end
   endtask

   // One request. Sender runs in bursts with random gaps; called and returns at a
   // falling edge. start stays high across back-to-back requests.
   task automatic send_key(input logic [KEY_W-1:0] k, input logic sn);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
         if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_payload <= '{key_bits: k, start_new: sn};
      start       <= 1'b1;
      @(posedge clock);
      while (busy) begin
         @(negedge clock);
         @(posedge clock);
      end
      groups.note_key(req_payload);
      keys_sent++;
      @(negedge clock);
   endtask

   // Writes both registers once the block has gone quiet: all responses in, busy low.
   // we stays high across the two writes so it never gets two updates in one step.
   task automatic apply_settings(input logic [CSR_DATA_W-1:0] kind_word,
                                 input logic [CSR_DATA_W-1:0] hb_word);
      start <= 1'b0;
      while (groups.outstanding() != 0 || busy) @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_KEY_TYPE;
      csr_wdata <= kind_word;
      @(negedge clock);
      groups.set_register(CSR_KEY_TYPE, kind_word);
      csr_index <= CSR_HASH_BITS;
      csr_wdata <= hb_word;
      @(negedge clock);
      groups.set_register(CSR_HASH_BITS, hb_word);
      csr_we <= 1'b0;
      phase_count++;
   endtask

   // 256-slot table filled past capacity: long probe runs, then full-table sweeps
   // mixed with hits on stored keys.
   task automatic fill_table();
      logic [KEY_W-1:0] k;
      apply_settings({2'b00, KIND_INT}, 4'd8);
      key_pool.delete();
      for (int i = 0; i < 320; i++) begin
         if (i >= 270 && $urandom_range(0, 1)) begin
            k = key_pool[$urandom_range(0, key_pool.size() - 1)];
         end else begin
            k = {$urandom(), $urandom()};
            key_pool.push_back(k);
         end
         send_key(k, i == 0);
      end
   endtask

   initial begin
      logic [KIND_W-1:0]     kind;
      logic [CSR_DATA_W-1:0] hb_word;
      int                    new_rate, len;

      groups      = new();
      start       = 1'b0;
      req_payload = '0;
      csr_we      = 1'b0;
      csr_index   = CSR_KEY_TYPE;
      csr_wdata   = '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // ---- directed ----
      // integers: extremes, upper half ignored on compare
      apply_settings({2'b00, KIND_INT}, 4'd12);
      send_key(64'h0, 1'b1);
      send_key(64'hffff_ffff_ffff_ffff, 1'b0);
      send_key(64'hffff_ffff_0000_0000, 1'b0);   // same int as 0
      send_key(64'h0000_0000_ffff_ffff, 1'b0);   // same int as -1
      send_key(64'h0000_0000_8000_0000, 1'b0);

      // doubles: signed zeros, NaNs never match, infinities, plain repeat
      apply_settings({2'b00, KIND_DOUBLE}, 4'd8);
      send_key(64'h0000_0000_0000_0000, 1'b1);
      send_key(64'h8000_0000_0000_0000, 1'b0);
      send_key(64'h7ff8_0000_0000_0000, 1'b0);
      send_key(64'h7ff8_0000_0000_0000, 1'b0);
      send_key(64'hfff0_0000_0000_0001, 1'b0);
      send_key(64'h7ff0_0000_0000_0000, 1'b0);
      send_key(64'h7ff0_0000_0000_0000, 1'b0);
      send_key(64'hfff0_0000_0000_0000, 1'b0);
      send_key(64'h3ff0_0000_0000_0000, 1'b0);
      send_key(64'h3ff0_0000_0000_0000, 1'b0);

      // pointers, table kept from the double phase; hash_bits below range acts as 8
      apply_settings({2'b00, KIND_PTR}, 4'd0);
      send_key(64'h1234_5678_0000_1000, 1'b0);
      send_key(64'h8765_4321_0000_1000, 1'b0);   // same fold, different pointer
      send_key(64'h1234_5678_0000_1000, 1'b0);

      // the spare key code acts as pointer; hash_bits above range clamps to table size
      apply_settings({2'b00, KIND_PTR_ALT}, 4'd15);
      send_key(64'hffff_ffff_ffff_ffff, 1'b0);
      send_key(64'hffff_ffff_ffff_ffff, 1'b0);
      send_key(64'h0, 1'b1);

      // ---- random phases ----
      // The first few hit every key code and the hash_bits extremes. Upper bits of the
      // key_type write are random to exercise the register mask.
      for (int phase = 0; keys_sent < KEY_TARGET; phase++) begin
         if (phase == FILL_PHASE) begin
            fill_table();
         end else begin
            case (phase)
               0: begin kind = KIND_INT;     hb_word = 4'd8;  end
               1: begin kind = KIND_DOUBLE;  hb_word = 4'd12; end
               2: begin kind = KIND_PTR;     hb_word = 4'd0;  end
               3: begin kind = KIND_PTR_ALT; hb_word = 4'd15; end
               default: begin
                  kind    = KIND_W'($urandom_range(KIND_INT, KIND_PTR_ALT));
                  hb_word = ($urandom_range(0, 9) < 7) ? CSR_DATA_W'($urandom_range(8, 12))
                                                       : CSR_DATA_W'($urandom_range(0, 15));
               end
            endcase
            apply_settings({2'($urandom_range(0, 3)), kind}, hb_word);
            refill_pool(kind, $urandom_range(4, 48));
            // table-clear rate varies: long-lived tables vs. heavy churn that wraps
            // the block's generation tag
            case ($urandom_range(0, 2))
               0: new_rate = 3;
               1: new_rate = 20;
               default: new_rate = 60;
            endcase
            len = $urandom_range(20, 80);
            for (int i = 0; i < len; i++)
               send_key(pick_key(kind), $urandom_range(0, 99) < new_rate);
         end
      end

      // ---- wind down ----
      start <= 1'b0;
      while (groups.outstanding() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      groups.flag_leftover();
      $display("Sent %0d keys across %0d register settings: %0d new groups, %0d repeats, %0d full",
               keys_sent, phase_count, groups.n_new, groups.n_hit, groups.n_full);
      $display("Response errors: %0d", groups.failures);
      if (groups.failures == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
